// ----- rtl/epra_pkg.sv -----
package epra_pkg;

    localparam int WINDOW_DEF    = 10;
    localparam int CHANNELS_DEF  = 3;
    localparam int TIME_BITS_DEF = 16;

    // range = floor(avg * 17 / 1000), i.e. avg * 0.034 / 2
    localparam int RANGE_MUL    = 17;
    localparam int RANGE_DIV    = 1000;
    localparam int RANGE_BITS   = 11;
    localparam int OUT_FIELDS   = 3;
    localparam int CHANNEL_BITS = 2;

    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_FETCH,
        SEQ_AVG,
        SEQ_RANGE,
        SEQ_EMIT
    } seq_state_t;

endpackage

// ----- rtl/echo_pulse_range_averager.sv -----
// capture transfer: accepted every cycle, also while a tick is in progress; no result
// tick transfer: result set by the window scan and a fetch/average/scale step per reported
//   channel, then emitted once the output register is free
// next tick taken once the result sits in the output register; a tick stalls until then
// reset (async, active low) clears channel state and sequencer; the window and total memories
//   are not swept, a fill count masks slots and totals not yet written
module echo_pulse_range_averager #(
    parameter int WINDOW    = epra_pkg::WINDOW_DEF,
    parameter int CHANNELS  = epra_pkg::CHANNELS_DEF,
    parameter int TIME_BITS = epra_pkg::TIME_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                op,
    input  logic [epra_pkg::CHANNEL_BITS-1:0]   channel,
    input  logic [TIME_BITS-1:0]                capture_time,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [epra_pkg::RANGE_BITS-1:0]     range_ch0,
    output logic [epra_pkg::RANGE_BITS-1:0]     range_ch1,
    output logic [epra_pkg::RANGE_BITS-1:0]     range_ch2
);

    localparam int CH_BITS       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_BITS     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_BITS     = $clog2(WINDOW + 1);
    localparam int TOT_BITS      = TIME_BITS + $clog2(WINDOW);
    localparam int RNG_BITS      = TIME_BITS + $clog2(epra_pkg::RANGE_MUL);
    localparam int SCAN_BITS     = $clog2(CHANNELS + 1);
    localparam int OUT_N         = (CHANNELS < epra_pkg::OUT_FIELDS) ? CHANNELS
                                                                     : epra_pkg::OUT_FIELDS;
    localparam int OUT_IDX_BITS  = $clog2(epra_pkg::OUT_FIELDS);
    localparam int WIN_ADDR_BITS = CH_BITS + SLOT_BITS;
    localparam int RB            = epra_pkg::RANGE_BITS;

    // reciprocals rounded up: exact floor for every total and every scaled average
    localparam int AVG_SHIFT  = TOT_BITS + $clog2(WINDOW);
    localparam int RNG_SHIFT  = RNG_BITS + $clog2(epra_pkg::RANGE_DIV);
    localparam int AVG_M_BITS = TOT_BITS + 1;
    localparam int RNG_M_BITS = RNG_BITS + 1 + $clog2(epra_pkg::RANGE_MUL);
    localparam int AVG_P_BITS = TOT_BITS + AVG_M_BITS;
    localparam int RNG_P_BITS = TIME_BITS + RNG_M_BITS;
    localparam logic [AVG_M_BITS-1:0] AVG_RECIP = AVG_M_BITS'(
        ((64'd1 << AVG_SHIFT) + 64'(WINDOW - 1)) / 64'(WINDOW));
    // the factor 17 is folded into the reciprocal of 1000
    localparam logic [RNG_M_BITS-1:0] RNG_RECIP = RNG_M_BITS'(64'(epra_pkg::RANGE_MUL)
        * (((64'd1 << RNG_SHIFT) + 64'(epra_pkg::RANGE_DIV - 1))
           / 64'(epra_pkg::RANGE_DIV)));

    // per-channel capture state
    logic                 armed_reg [CHANNELS];
    logic                 first_reg [CHANNELS];
    logic [TIME_BITS-1:0] rise_reg  [CHANNELS];
    logic [TIME_BITS-1:0] width_reg [CHANNELS];
    logic [TIME_BITS-1:0] snap_reg  [CHANNELS];

    // sequencer
    epra_pkg::seq_state_t  state_reg;
    epra_pkg::seq_state_t  state_next;
    logic [SCAN_BITS-1:0]  scan_cnt_reg;
    logic [OUT_IDX_BITS-1:0] div_ch_reg;
    logic                  scan_wr_vld_reg;
    logic [CH_BITS-1:0]    scan_ch_reg;
    logic [SLOT_BITS-1:0]  slot_reg;
    logic [FILL_BITS-1:0]  fill_reg;

    // scaling
    logic [TIME_BITS-1:0]  avg_reg;
    logic [RB-1:0]         range_reg [epra_pkg::OUT_FIELDS];

    // output register
    logic                  result_valid_reg;
    logic [RB-1:0]         range_ch0_reg;
    logic [RB-1:0]         range_ch1_reg;
    logic [RB-1:0]         range_ch2_reg;

    logic cap_fire;
    logic tick_fire;
    logic cap_hit;
    logic [CH_BITS-1:0]   ch_idx;
    logic [TIME_BITS-1:0] rise_sel;

    logic scan_rd;
    logic fetch_rd;
    logic avg_load;
    logic range_store;
    logic emit_load;
    logic scan_done;
    logic div_last;
    logic out_free;

    logic [WIN_ADDR_BITS-1:0] win_rd_addr;
    logic [WIN_ADDR_BITS-1:0] win_wr_addr;
    logic [TIME_BITS-1:0]     win_rd_data;
    logic [CH_BITS-1:0]       tot_rd_addr;
    logic                     tot_rd_en;
    logic [TOT_BITS-1:0]      tot_rd_data;
    logic [TIME_BITS-1:0]     old_win;
    logic [TOT_BITS-1:0]      old_tot;
    logic [TOT_BITS-1:0]      new_tot;
    logic [TIME_BITS-1:0]     snap_sel;

    logic [AVG_P_BITS-1:0]    avg_prod;
    logic [RNG_P_BITS-1:0]    rng_prod;
    logic [TIME_BITS-1:0]     avg_next;
    logic [RB-1:0]            range_next;

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    assign item_stall = (state_reg != epra_pkg::SEQ_IDLE) && (op == epra_pkg::OP_TICK);
    assign cap_fire   = item_valid && !item_stall && (op == epra_pkg::OP_CAPTURE);
    assign tick_fire  = item_valid && !item_stall && (op == epra_pkg::OP_TICK);
    assign cap_hit    = cap_fire && (int'(channel) < CHANNELS);
    assign ch_idx     = CH_BITS'(channel);
    assign rise_sel   = rise_reg[ch_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                armed_reg[c] <= 1'b1;
                first_reg[c] <= 1'b0;
                rise_reg[c]  <= '0;
                width_reg[c] <= '0;
                snap_reg[c]  <= '0;
            end
        end
        else if (tick_fire)
        begin
            // widths are frozen here so later captures do not leak into this tick
            for (int c = 0; c < CHANNELS; c++)
            begin
                armed_reg[c] <= 1'b1;
                snap_reg[c]  <= width_reg[c];
            end
        end
        else if (cap_hit && armed_reg[ch_idx])
        begin
            if (!first_reg[ch_idx])
            begin
                rise_reg[ch_idx]  <= capture_time;
                first_reg[ch_idx] <= 1'b1;
            end
            else
            begin
                if (capture_time > rise_sel)
                begin
                    width_reg[ch_idx] <= capture_time - rise_sel;
                end
                else if (capture_time < rise_sel)
                begin
                    // timer wrapped: max - rise + fall
                    width_reg[ch_idx] <= ~rise_sel + capture_time;
                end
                first_reg[ch_idx] <= 1'b0;
                armed_reg[ch_idx] <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign scan_done = (state_reg == epra_pkg::SEQ_SCAN)
                       && (scan_cnt_reg == SCAN_BITS'(CHANNELS));
    assign div_last  = div_ch_reg == OUT_IDX_BITS'(OUT_N - 1);
    assign out_free  = !result_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            epra_pkg::SEQ_IDLE:
            begin
                if (tick_fire)
                begin
                    state_next = epra_pkg::SEQ_SCAN;
                end
            end
            epra_pkg::SEQ_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = epra_pkg::SEQ_FETCH;
                end
            end
            epra_pkg::SEQ_FETCH:      state_next = epra_pkg::SEQ_AVG;
            epra_pkg::SEQ_AVG:        state_next = epra_pkg::SEQ_RANGE;
            epra_pkg::SEQ_RANGE:
            begin
                state_next = div_last ? epra_pkg::SEQ_EMIT : epra_pkg::SEQ_FETCH;
            end
            epra_pkg::SEQ_EMIT:
            begin
                if (out_free)
                begin
                    state_next = epra_pkg::SEQ_IDLE;
                end
            end
            default:                  state_next = epra_pkg::SEQ_IDLE;
        endcase
    end

    always_comb
    begin
        scan_rd     = 1'b0;
        fetch_rd    = 1'b0;
        avg_load    = 1'b0;
        range_store = 1'b0;
        emit_load   = 1'b0;
        case (state_reg)
            epra_pkg::SEQ_SCAN:       scan_rd = int'(scan_cnt_reg) < CHANNELS;
            epra_pkg::SEQ_FETCH:      fetch_rd = 1'b1;
            epra_pkg::SEQ_AVG:        avg_load = 1'b1;
            epra_pkg::SEQ_RANGE:      range_store = 1'b1;
            epra_pkg::SEQ_EMIT:       emit_load = out_free;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= epra_pkg::SEQ_IDLE;
            scan_cnt_reg    <= '0;
            div_ch_reg      <= '0;
            scan_wr_vld_reg <= 1'b0;
            scan_ch_reg     <= '0;
            slot_reg        <= '0;
            fill_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            scan_wr_vld_reg <= scan_rd;
            scan_ch_reg     <= CH_BITS'(scan_cnt_reg);
            if (tick_fire)
            begin
                scan_cnt_reg <= '0;
            end
            else if (state_reg == epra_pkg::SEQ_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            if (scan_done)
            begin
                slot_reg <= (int'(slot_reg) == WINDOW - 1) ? '0 : slot_reg + 1'b1;
                if (int'(fill_reg) != WINDOW)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (range_store)
            begin
                div_ch_reg <= div_last ? '0 : div_ch_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // window and running total memories
    // read channel k, write it back in the next cycle
    // ------------------------------------------------------------------
    assign win_rd_addr = {CH_BITS'(scan_cnt_reg), slot_reg};
    assign win_wr_addr = {scan_ch_reg, slot_reg};
    assign tot_rd_en   = scan_rd || fetch_rd;
    assign tot_rd_addr = fetch_rd ? CH_BITS'(div_ch_reg) : CH_BITS'(scan_cnt_reg);
    assign snap_sel    = snap_reg[scan_ch_reg];

    // slots at or past the fill count were never written and count as zero
    assign old_win = (FILL_BITS'(slot_reg) < fill_reg) ? win_rd_data : '0;
    assign old_tot = (fill_reg != '0) ? tot_rd_data : '0;
    assign new_tot = old_tot - TOT_BITS'(old_win) + TOT_BITS'(snap_sel);

    epra_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (2 ** WIN_ADDR_BITS)
    ) u_win_ram (
        .clk     (clk),
        .wr_en   (scan_wr_vld_reg),
        .wr_addr (win_wr_addr),
        .wr_data (snap_sel),
        .rd_en   (scan_rd),
        .rd_addr (win_rd_addr),
        .rd_data (win_rd_data)
    );

    epra_ram #(
        .WIDTH (TOT_BITS),
        .DEPTH (2 ** CH_BITS)
    ) u_tot_ram (
        .clk     (clk),
        .wr_en   (scan_wr_vld_reg),
        .wr_addr (scan_ch_reg),
        .wr_data (new_tot),
        .rd_en   (tot_rd_en),
        .rd_addr (tot_rd_addr),
        .rd_data (tot_rd_data)
    );

    // ------------------------------------------------------------------
    // reciprocal multiply, one product per cycle
    // total / WINDOW first, then (avg * 17) / 1000
    // ------------------------------------------------------------------
    assign avg_prod   = AVG_P_BITS'(tot_rd_data) * AVG_P_BITS'(AVG_RECIP);
    assign avg_next   = TIME_BITS'(avg_prod >> AVG_SHIFT);
    assign rng_prod   = RNG_P_BITS'(avg_reg) * RNG_P_BITS'(RNG_RECIP);
    assign range_next = RB'(rng_prod >> RNG_SHIFT);

    always_ff @(posedge clk)
    begin
        if (avg_load)
        begin
            avg_reg <= avg_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < epra_pkg::OUT_FIELDS; i++)
            begin
                range_reg[i] <= '0;
            end
        end
        else if (range_store)
        begin
            range_reg[div_ch_reg] <= range_next;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            range_ch0_reg <= range_reg[0];
            range_ch1_reg <= range_reg[1];
            range_ch2_reg <= range_reg[2];
        end
    end

    assign result_valid = result_valid_reg;
    assign range_ch0    = range_ch0_reg;
    assign range_ch1    = range_ch1_reg;
    assign range_ch2    = range_ch2_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_tick_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tick_fire |=> state_reg == epra_pkg::SEQ_SCAN)
        else $error("tick transfer did not start the window scan");

    a_slot_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(fill_reg) <= WINDOW) && (int'(slot_reg) < WINDOW))
        else $error("window slot or fill count out of range");

    a_second_edge_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        (cap_hit && armed_reg[ch_idx] && first_reg[ch_idx])
        |=> !armed_reg[$past(ch_idx)] && !first_reg[$past(ch_idx)])
        else $error("second edge left the channel armed");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg) == epra_pkg::SEQ_EMIT)
        else $error("result raised outside the emit step");

    a_div_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(div_ch_reg) < OUT_N)
        else $error("divider channel index out of range");

endmodule

// ----- rtl/epra_ram.sv -----
module epra_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                          clk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic                                          rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- tb/epra_range_check.sv -----
module epra_range_check (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    input  logic                                  item_stall,
    input  logic                                  op,
    input  logic [epra_pkg::CHANNEL_BITS-1:0]     channel,
    input  logic [epra_pkg::TIME_BITS_DEF-1:0]    capture_time,
    input  logic                                  result_valid,
    input  logic                                  result_stall,
    input  logic [epra_pkg::RANGE_BITS-1:0]       range_ch0,
    input  logic [epra_pkg::RANGE_BITS-1:0]       range_ch1,
    input  logic [epra_pkg::RANGE_BITS-1:0]       range_ch2,
    output int                                    mismatches,
    output int                                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH = epra_pkg::CHANNELS_DEF;
    localparam int WIN = epra_pkg::WINDOW_DEF;
    localparam int NOUT = epra_pkg::OUT_FIELDS;

    typedef logic [epra_pkg::TIME_BITS_DEF-1:0] stamp_t;
    typedef logic [epra_pkg::RANGE_BITS-1:0] range_t;
    typedef logic [NOUT-1:0][epra_pkg::RANGE_BITS-1:0] ranges_t;

    localparam stamp_t TIME_MAX = '1;

    logic        armed [NCH];
    logic        rise_seen [NCH];
    stamp_t      rise_at [NCH];
    stamp_t      pulse [NCH];
    stamp_t      history [NCH][WIN];
    logic [19:0] width_sum [NCH];
    int          slot;
    ranges_t     expected_q [$];

    // returns 1 when the item is a tick and ranges holds the report it causes
    function automatic bit predict_ranges(input logic kind, input int ch, input stamp_t t,
                                          output ranges_t ranges);
        int avg;
        ranges = '0;
        if (kind == epra_pkg::OP_CAPTURE)
        begin
            if (ch < NCH && armed[ch])
            begin
                if (!rise_seen[ch])
                begin
                    rise_at[ch] = t;
                    rise_seen[ch] = 1'b1;
                end
                else
                begin
                    // equal stamps leave the old width in place
                    if (t > rise_at[ch])
                        pulse[ch] = t - rise_at[ch];
                    else if (t < rise_at[ch])
                        pulse[ch] = TIME_MAX - rise_at[ch] + t;
                    rise_seen[ch] = 1'b0;
                    armed[ch] = 1'b0;
                end
            end
            return 1'b0;
        end
        for (int c = 0; c < NCH; c++)
        begin
            armed[c] = 1'b1;
            width_sum[c] = width_sum[c] - history[c][slot] + pulse[c];
            history[c][slot] = pulse[c];
        end
        slot = (slot + 1 == WIN) ? 0 : slot + 1;
        for (int c = 0; c < NCH; c++)
        begin
            avg = int'(width_sum[c]) / WIN;
            ranges[c] = range_t'((avg * epra_pkg::RANGE_MUL) / epra_pkg::RANGE_DIV);
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        ranges_t got;
        ranges_t want;
        if (!rst_n)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                armed[c] = 1'b1;
                rise_seen[c] = 1'b0;
                rise_at[c] = '0;
                pulse[c] = '0;
                width_sum[c] = '0;
                for (int s = 0; s < WIN; s++)
                    history[c][s] = '0;
            end
            slot = 0;
            expected_q.delete();
            mismatches = 0;
        end
        else
        begin
            // result first: a tick taken at this edge cannot be reported at the same edge
            if (result_valid && !result_stall)
            begin
                got = {range_ch2, range_ch1, range_ch0};
                if (expected_q.size() == 0)
                begin
                    $display("%0t: range transfer with none expected, actual %0d %0d %0d",
                             $time, range_ch0, range_ch1, range_ch2);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    for (int c = 0; c < NOUT; c++)
                    begin
                        if (got[c] !== want[c])
                        begin
                            $display("%0t: range_ch%0d expected %0d, actual %0d",
                                     $time, c, want[c], got[c]);
                            mismatches++;
                        end
                    end
                end
            end
            if (item_valid && !item_stall && predict_ranges(op, channel, capture_time, want))
                expected_q.push_back(want);
        end
        pending = expected_q.size();
    end

endmodule

// ----- tb/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH            = epra_pkg::CHANNELS_DEF;
    localparam int ITEM_TARGET    = 1950;
    localparam int HOLD_OFF       = 800;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 200;

    typedef logic [epra_pkg::TIME_BITS_DEF-1:0] stamp_t;
    typedef logic [epra_pkg::CHANNEL_BITS-1:0] chan_t;
    typedef enum logic [1:0] {SPREAD_ANY, SPREAD_LONG, SPREAD_SHORT} spread_t;

    logic   clk;
    logic   rst_n;
    logic   item_valid;
    logic   item_stall;
    logic   op;
    chan_t  channel;
    stamp_t capture_time;
    logic   result_valid;
    logic   result_stall;
    logic [epra_pkg::RANGE_BITS-1:0] range_ch0;
    logic [epra_pkg::RANGE_BITS-1:0] range_ch1;
    logic [epra_pkg::RANGE_BITS-1:0] range_ch2;

    int      mismatches;
    int      pending;
    int      idle_cycles = 0;
    int      items_done = 0;
    int      send_quiet = 0;
    bit      random_phase = 1'b0;
    spread_t spread = SPREAD_ANY;

    echo_pulse_range_averager dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (op),
        .channel      (channel),
        .capture_time (capture_time),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .range_ch0    (range_ch0),
        .range_ch1    (range_ch1),
        .range_ch2    (range_ch2)
    );

    epra_range_check range_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (op),
        .channel      (channel),
        .capture_time (capture_time),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .range_ch0    (range_ch0),
        .range_ch1    (range_ch1),
        .range_ch2    (range_ch2),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // mostly short gaps, a few long ones, and now and then a run with none
    function automatic int idle_len(inout int quiet_left);
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            quiet_left = $urandom_range(20, 80);
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(15, 60);
        if ($urandom_range(0, 9) < 6)
            return 0;
        return $urandom_range(1, 4);
    endfunction

    // returns after the transfer edge; valid stays up until the next call decides
    task automatic send_item(input logic kind, input chan_t ch, input stamp_t t);
        int gap;
        gap = idle_len(send_quiet);
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        op <= kind;
        channel <= ch;
        capture_time <= t;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_done++;
    endtask

    task automatic send_tick();
        send_item(epra_pkg::OP_TICK, chan_t'($urandom_range(0, 3)), stamp_t'($urandom));
    endtask

    // one measurement: rise edges, fall edges in rotated order, some noise, then a tick (now and then two)
    task automatic measure_round();
        stamp_t rise_t [NCH];
        stamp_t fall_t [NCH];
        bit     used [NCH];
        bit     broken [NCH];
        int     first;
        int     c;
        if ($urandom_range(0, 14) == 0)
            spread = spread_t'($urandom_range(0, 2));
        for (c = 0; c < NCH; c++)
        begin
            used[c] = ($urandom_range(0, 9) != 0);
            broken[c] = ($urandom_range(0, 11) == 0);
            rise_t[c] = stamp_t'($urandom);
            case (spread)
                SPREAD_LONG:
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        rise_t[c] = stamp_t'($urandom_range(0, 31));
                        fall_t[c] = stamp_t'(16'hFFFF - $urandom_range(0, 31));
                    end
                    else
                    begin
                        // wrapping pulse just short of the full timer span
                        rise_t[c] = stamp_t'($urandom_range(40, 16'hFFFF));
                        fall_t[c] = rise_t[c] - stamp_t'($urandom_range(1, 32));
                    end
                end
                SPREAD_SHORT:
                    fall_t[c] = rise_t[c] + stamp_t'($urandom_range(1, 2000));
                default:
                    fall_t[c] = stamp_t'($urandom);
            endcase
            if ($urandom_range(0, 15) == 0)
                fall_t[c] = rise_t[c];
        end
        for (c = 0; c < NCH; c++)
        begin
            if (used[c])
                send_item(epra_pkg::OP_CAPTURE, chan_t'(c), rise_t[c]);
        end
        first = $urandom_range(0, NCH - 1);
        for (int i = 0; i < NCH; i++)
        begin
            c = (first + i) % NCH;
            if (used[c] && !broken[c])
                send_item(epra_pkg::OP_CAPTURE, chan_t'(c), fall_t[c]);
        end
        if ($urandom_range(0, 3) == 0)
            send_item(epra_pkg::OP_CAPTURE, chan_t'($urandom_range(NCH, 3)), stamp_t'($urandom));
        if ($urandom_range(0, 3) == 0)
            send_item(epra_pkg::OP_CAPTURE, chan_t'($urandom_range(0, NCH - 1)),
                      stamp_t'($urandom));
        send_tick();
        if ($urandom_range(0, 9) == 0)
            send_tick();
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        op = epra_pkg::OP_CAPTURE;
        channel = '0;
        capture_time = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_tick();
        // full span, wrap to zero width, wrap just short of full span
        send_item(epra_pkg::OP_CAPTURE, 2'd0, 16'h0000);
        send_item(epra_pkg::OP_CAPTURE, 2'd0, 16'hFFFF);
        send_item(epra_pkg::OP_CAPTURE, 2'd1, 16'hFFFF);
        send_item(epra_pkg::OP_CAPTURE, 2'd1, 16'h0000);
        send_item(epra_pkg::OP_CAPTURE, 2'd2, 16'h0001);
        send_item(epra_pkg::OP_CAPTURE, 2'd2, 16'h0000);
        // edge on a disarmed channel, then on a channel that does not exist
        send_item(epra_pkg::OP_CAPTURE, 2'd0, 16'h4321);
        send_item(epra_pkg::OP_CAPTURE, 2'd3, 16'hFFFF);
        send_item(epra_pkg::OP_TICK, 2'd3, 16'hFFFF);
        // equal stamps keep the old width
        send_item(epra_pkg::OP_CAPTURE, 2'd0, 16'h1234);
        send_item(epra_pkg::OP_CAPTURE, 2'd0, 16'h1234);
        send_item(epra_pkg::OP_CAPTURE, 2'd1, 16'h8000);
        send_item(epra_pkg::OP_CAPTURE, 2'd1, 16'h7FFF);
        send_item(epra_pkg::OP_CAPTURE, 2'd2, 16'hAAAA);
        send_item(epra_pkg::OP_CAPTURE, 2'd2, 16'h5555);
        send_item(epra_pkg::OP_TICK, 2'd2, 16'h5555);
        send_item(epra_pkg::OP_TICK, 2'd1, 16'h0000);
        send_item(epra_pkg::OP_TICK, 2'd0, 16'h0000);

        random_phase = 1'b1;
        items_done = 0;
        while (items_done < ITEM_TARGET)
            measure_round();
        @(negedge clk);
        item_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("echo_pulse_range_averager test passed");
        else
            $display("echo_pulse_range_averager test failed");
        $finish;
    end

    initial
    begin : result_side
        int  n;
        int  quiet;
        bit  held;
        quiet = 0;
        held = 1'b0;
        result_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            // one long hold-off while the sender keeps offering, so the block backs up
            if (random_phase && !held)
            begin
                held = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_OFF) @(negedge clk);
            end
            n = idle_len(quiet);
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            result_stall <= 1'b0;
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("echo_pulse_range_averager test failed");
            $finish;
        end
    end

endmodule
